@@ hdl/sbq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbq_pkg
// Shared widths, register codes and the coefficient bundle of the stereo
// biquad filter with output clipping.
// ----------------------------------------------------------------------------
package sbq_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_BITS      = 24;
  localparam int COEF_FRAC_BITS = 20;
  localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;
  // five products plus headroom for the rounding add
  localparam int ACC_BITS       = PROD_BITS + 3;
  localparam int CFG_IDX_BITS   = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } sbq_reg_e;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] b0;
    logic signed [COEF_BITS-1:0] b1;
    logic signed [COEF_BITS-1:0] b2;
    logic signed [COEF_BITS-1:0] a1;
    logic signed [COEF_BITS-1:0] a2;
  } sbq_coef_t;

endpackage
`default_nettype wire

@@ hdl/sbq_coef_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbq_coef_regs
// Coefficient register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module sbq_coef_regs (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [sbq_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  wire logic [sbq_pkg::COEF_BITS-1:0]      cfg_data_i,
  output sbq_pkg::sbq_coef_t                      coef_o
);
  import sbq_pkg::*;

  sbq_coef_t coef_q, coef_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    coef_d = coef_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_B0:  coef_d.b0 = cfg_data_i;
        REG_B1:  coef_d.b1 = cfg_data_i;
        REG_B2:  coef_d.b2 = cfg_data_i;
        REG_A1:  coef_d.a1 = cfg_data_i;
        REG_A2:  coef_d.a2 = cfg_data_i;
        default: coef_d = coef_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.b0 <= COEF_BITS'(1) << COEF_FRAC_BITS;
      coef_q.b1 <= '0;
      coef_q.b2 <= '0;
      coef_q.a1 <= '0;
      coef_q.a2 <= '0;
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule
`default_nettype wire

@@ hdl/sbq_channel.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbq_channel
// One direct-form-I biquad section with rounding, saturation and its own
// input and output history.
// ----------------------------------------------------------------------------
module sbq_channel (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                advance_i,
  input  wire logic signed [sbq_pkg::SAMPLE_BITS-1:0] x_i,
  input  wire sbq_pkg::sbq_coef_t                  coef_i,
  output logic signed [sbq_pkg::SAMPLE_BITS-1:0]   y_o
);
  import sbq_pkg::*;

  localparam logic signed [ACC_BITS-1:0] SatMax =
    {{(ACC_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] SatMin =
    {{(ACC_BITS-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [ACC_BITS-1:0] RoundBias =
    ACC_BITS'(1) << (COEF_FRAC_BITS - 1);

  logic signed [SAMPLE_BITS-1:0] x1_q, x2_q, y1_q, y2_q;
  logic signed [PROD_BITS-1:0]   p_b0, p_b1, p_b2, p_a1, p_a2;
  logic signed [ACC_BITS-1:0]    acc, acc_rnd, acc_sh;

  assign p_b0 = PROD_BITS'(x_i)  * PROD_BITS'(coef_i.b0);
  assign p_b1 = PROD_BITS'(x1_q) * PROD_BITS'(coef_i.b1);
  assign p_b2 = PROD_BITS'(x2_q) * PROD_BITS'(coef_i.b2);
  assign p_a1 = PROD_BITS'(y1_q) * PROD_BITS'(coef_i.a1);
  assign p_a2 = PROD_BITS'(y2_q) * PROD_BITS'(coef_i.a2);

  assign acc = ACC_BITS'(p_b0) + ACC_BITS'(p_b1) + ACC_BITS'(p_b2)
             - ACC_BITS'(p_a1) - ACC_BITS'(p_a2);
  // round half up, then drop the coefficient fraction
  assign acc_rnd = acc + RoundBias;
  assign acc_sh  = acc_rnd >>> COEF_FRAC_BITS;

  always_comb begin
    if (acc_sh > SatMax) begin
      y_o = SatMax[SAMPLE_BITS-1:0];
    end else if (acc_sh < SatMin) begin
      y_o = SatMin[SAMPLE_BITS-1:0];
    end else begin
      y_o = acc_sh[SAMPLE_BITS-1:0];
    end
  end

  // clipped value feeds back into the output history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= '0;
      x2_q <= '0;
      y1_q <= '0;
      y2_q <= '0;
    end else if (advance_i) begin
      x1_q <= x_i;
      x2_q <= x1_q;
      y1_q <= y_o;
      y2_q <= y1_q;
    end
  end

endmodule
`default_nettype wire

@@ hdl/stereo_biquad_filter_clip_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_biquad_filter_clip_unit
// Stereo direct-form-I biquad with shared coefficients and output clipping.
// ----------------------------------------------------------------------------
// Takes one stereo frame per clock cycle unless the output is stalled, and
// returns one filtered frame for each through the input and result registers.
// Samples are signed Q1.23, coefficients signed Q4.20 (b0, b1, b2, a1, a2 at
// indexes 0 to 4; other indexes are ignored). The figure of one frame per
// cycle is set by the per-channel section between the input and result
// registers: five multiplies, the sum, rounding and clipping, whose clipped
// output is fed back as history in the same cycle. Write coefficients only
// while no frame is in flight; the history is kept across writes.
// ----------------------------------------------------------------------------
module stereo_biquad_filter_clip_unit (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  wire logic [sbq_pkg::CFG_IDX_BITS-1:0]       cfg_index_i,
  input  wire logic [sbq_pkg::COEF_BITS-1:0]          cfg_data_i,
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic signed [sbq_pkg::SAMPLE_BITS-1:0] sample_left_i,
  input  wire logic signed [sbq_pkg::SAMPLE_BITS-1:0] sample_right_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic signed [sbq_pkg::SAMPLE_BITS-1:0]      out_left_o,
  output logic signed [sbq_pkg::SAMPLE_BITS-1:0]      out_right_o
);
  import sbq_pkg::*;

  sbq_coef_t                 coef;
  logic                      in_valid_q, out_valid_q;
  logic signed [SAMPLE_BITS-1:0] x_left_q, x_right_q;
  logic signed [SAMPLE_BITS-1:0] y_left, y_right;
  logic signed [SAMPLE_BITS-1:0] out_left_q, out_right_q;
  logic                      advance, in_load;

  // frame moves to the result register when that one is free or drains
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_load    = !in_valid_q || advance;
  assign in_stall_o = !in_load;

  sbq_coef_regs u_coef (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .coef_o      (coef)
  );

  sbq_channel u_left (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .x_i       (x_left_q),
    .coef_i    (coef),
    .y_o       (y_left)
  );

  sbq_channel u_right (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .x_i       (x_right_q),
    .coef_i    (coef),
    .y_o       (y_right)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_load) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) begin
      x_left_q  <= sample_left_i;
      x_right_q <= sample_right_i;
    end
    if (advance) begin
      out_left_q  <= y_left;
      out_right_q <= y_right;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_left_o  = out_left_q;
  assign out_right_o = out_right_q;

endmodule
`default_nettype wire
